FILE: rtl/tgr_pkg.sv
// ----------------------------------------------------------------------------
// tgr_pkg
// Shared types, constants and the font table of the text glyph renderer.
// ----------------------------------------------------------------------------
package tgr_pkg;

  localparam int FRAME_BYTES = 1024;
  localparam int ROW_BYTES   = 128;
  localparam int GLYPH_COUNT = 75;
  localparam int GLYPH_COLS  = 7;

  localparam int CURSOR_W = 16;
  localparam int ADDR_W   = 10;
  localparam int SUM_W    = CURSOR_W + 1;
  localparam int IDX_W    = $clog2(GLYPH_COUNT);
  localparam int LEN_W    = $clog2(GLYPH_COLS + 1);
  localparam int COL_W    = $clog2(GLYPH_COLS);

  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_FIRST   = 8'd32;
  localparam logic [7:0] CHAR_LOWER_A = 8'd97;
  localparam logic [7:0] CHAR_LOWER_Z = 8'd122;
  localparam logic [7:0] CHAR_EXTRA   = 8'd123;
  localparam logic [7:0] CHAR_LAST    = 8'd132;

  // status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_BADCHAR = 2'd1;
  localparam logic [1:0] STAT_CLIPPED = 2'd2;

  // configuration register indexes
  localparam logic CFG_INVERT = 1'b0;
  localparam logic CFG_DOUBLE = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_EMIT,
    S_ERR
  } state_t;

  typedef struct packed {
    logic [LEN_W-1:0]               len;
    logic [GLYPH_COLS-1:0][7:0]     cols;
  } glyph_t;

  function automatic glyph_t mk(input logic [LEN_W-1:0] len,
                                input logic [7:0] c0, input logic [7:0] c1,
                                input logic [7:0] c2, input logic [7:0] c3,
                                input logic [7:0] c4, input logic [7:0] c5,
                                input logic [7:0] c6);
    glyph_t g;
    g.len     = len;
    g.cols[0] = c0;
    g.cols[1] = c1;
    g.cols[2] = c2;
    g.cols[3] = c3;
    g.cols[4] = c4;
    g.cols[5] = c5;
    g.cols[6] = c6;
    return g;
  endfunction

  function automatic glyph_t font_word(input logic [IDX_W-1:0] idx);
    glyph_t g;
    g = '0;
    case (idx)
      7'd0:  g = mk(3'd6, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      7'd1:  g = mk(3'd2, 8'h00, 8'hBE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      7'd2:  g = mk(3'd4, 8'h00, 8'h06, 8'h00, 8'h06, 8'h00, 8'h00, 8'h00);
      7'd3:  g = mk(3'd6, 8'h00, 8'h28, 8'hFE, 8'h28, 8'hFE, 8'h28, 8'h00);
      7'd4:  g = mk(3'd6, 8'h00, 8'h48, 8'h54, 8'hFE, 8'h54, 8'h24, 8'h00);
      7'd5:  g = mk(3'd6, 8'h00, 8'h84, 8'h6A, 8'h54, 8'hAC, 8'h42, 8'h00);
      7'd6:  g = mk(3'd6, 8'h00, 8'h6C, 8'h92, 8'hB2, 8'h4C, 8'hA0, 8'h00);
      7'd7:  g = mk(3'd2, 8'h00, 8'h06, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      7'd8:  g = mk(3'd4, 8'h00, 8'h00, 8'h7C, 8'h82, 8'h00, 8'h00, 8'h00);
      7'd9:  g = mk(3'd4, 8'h00, 8'h82, 8'h7C, 8'h00, 8'h00, 8'h00, 8'h00);
      7'd10: g = mk(3'd4, 8'h00, 8'h0A, 8'h04, 8'h0A, 8'h00, 8'h00, 8'h00);
      7'd11: g = mk(3'd6, 8'h00, 8'h10, 8'h10, 8'h7C, 8'h10, 8'h10, 8'h00);
      7'd12: g = mk(3'd2, 8'h00, 8'hC0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      7'd13: g = mk(3'd6, 8'h10, 8'h10, 8'h10, 8'h10, 8'h10, 8'h10, 8'h00);
      7'd14: g = mk(3'd3, 8'h00, 8'hC0, 8'hC0, 8'h00, 8'h00, 8'h00, 8'h00);
      7'd15: g = mk(3'd6, 8'h00, 8'h80, 8'h60, 8'h10, 8'h0C, 8'h02, 8'h00);
      7'd16: g = mk(3'd6, 8'h00, 8'h7C, 8'hE2, 8'h92, 8'h8E, 8'h7C, 8'h00);
      7'd17: g = mk(3'd6, 8'h00, 8'h82, 8'h82, 8'hFE, 8'h80, 8'h80, 8'h00);
      7'd18: g = mk(3'd6, 8'h00, 8'hE4, 8'h92, 8'h92, 8'h92, 8'h8C, 8'h00);
      7'd19: g = mk(3'd6, 8'h00, 8'h44, 8'h82, 8'h92, 8'h92, 8'h6C, 8'h00);
      7'd20: g = mk(3'd6, 8'h00, 8'h1E, 8'h10, 8'h10, 8'h10, 8'hFE, 8'h00);
      7'd21: g = mk(3'd6, 8'h00, 8'h4E, 8'h92, 8'h92, 8'h92, 8'h62, 8'h00);
      7'd22: g = mk(3'd6, 8'h00, 8'h7C, 8'h92, 8'h92, 8'h92, 8'h64, 8'h00);
      7'd23: g = mk(3'd6, 8'h00, 8'h82, 8'h62, 8'h12, 8'h0E, 8'h02, 8'h00);
      7'd24: g = mk(3'd6, 8'h00, 8'h6C, 8'h92, 8'h92, 8'h92, 8'h6C, 8'h00);
      7'd25: g = mk(3'd6, 8'h00, 8'h4C, 8'h92, 8'h92, 8'h92, 8'h7C, 8'h00);
      7'd26: g = mk(3'd3, 8'h00, 8'hC6, 8'hC6, 8'h00, 8'h00, 8'h00, 8'h00);
      7'd27: g = mk(3'd3, 8'h00, 8'hC6, 8'h06, 8'h00, 8'h00, 8'h00, 8'h00);
      7'd28: g = mk(3'd6, 8'h00, 8'h10, 8'h28, 8'h44, 8'h82, 8'h00, 8'h00);
      7'd29: g = mk(3'd6, 8'h00, 8'h28, 8'h28, 8'h28, 8'h28, 8'h28, 8'h00);
      7'd30: g = mk(3'd6, 8'h00, 8'h82, 8'h44, 8'h28, 8'h10, 8'h00, 8'h00);
      7'd31: g = mk(3'd6, 8'h00, 8'h04, 8'h02, 8'hB2, 8'h12, 8'h0C, 8'h00);
      7'd32: g = mk(3'd7, 8'h00, 8'h38, 8'h54, 8'hAA, 8'hBA, 8'hA4, 8'h18);
      7'd33: g = mk(3'd6, 8'h00, 8'hFC, 8'h12, 8'h12, 8'h12, 8'hFE, 8'h00);
      7'd34: g = mk(3'd6, 8'h00, 8'hFE, 8'h92, 8'h92, 8'h92, 8'h6C, 8'h00);
      7'd35: g = mk(3'd6, 8'h00, 8'h7C, 8'h82, 8'h82, 8'h82, 8'h44, 8'h00);
      7'd36: g = mk(3'd6, 8'h00, 8'hFE, 8'h82, 8'h82, 8'h82, 8'h7C, 8'h00);
      7'd37: g = mk(3'd6, 8'h00, 8'hFE, 8'h92, 8'h92, 8'h92, 8'h82, 8'h00);
      7'd38: g = mk(3'd6, 8'h00, 8'hFE, 8'h12, 8'h12, 8'h12, 8'h02, 8'h00);
      7'd39: g = mk(3'd6, 8'h00, 8'h7E, 8'h82, 8'h82, 8'h92, 8'h74, 8'h00);
      7'd40: g = mk(3'd6, 8'h00, 8'hFE, 8'h10, 8'h10, 8'h10, 8'hFE, 8'h00);
      7'd41: g = mk(3'd6, 8'h00, 8'h82, 8'h82, 8'hFE, 8'h82, 8'h82, 8'h00);
      7'd42: g = mk(3'd6, 8'h00, 8'h40, 8'h80, 8'h82, 8'h82, 8'h7E, 8'h00);
      7'd43: g = mk(3'd6, 8'h00, 8'hFE, 8'h10, 8'h10, 8'h28, 8'hC6, 8'h00);
      7'd44: g = mk(3'd6, 8'h00, 8'hFE, 8'h80, 8'h80, 8'h80, 8'h80, 8'h00);
      7'd45: g = mk(3'd6, 8'h00, 8'hFE, 8'h02, 8'h1C, 8'h02, 8'hFE, 8'h00);
      7'd46: g = mk(3'd6, 8'h00, 8'hFE, 8'h0C, 8'h10, 8'h60, 8'hFE, 8'h00);
      7'd47: g = mk(3'd6, 8'h00, 8'h7C, 8'h82, 8'h82, 8'h82, 8'h7C, 8'h00);
      7'd48: g = mk(3'd6, 8'h00, 8'hFE, 8'h12, 8'h12, 8'h12, 8'h0C, 8'h00);
      7'd49: g = mk(3'd6, 8'h00, 8'h7C, 8'h82, 8'hA2, 8'h42, 8'hBC, 8'h00);
      7'd50: g = mk(3'd6, 8'h00, 8'hFE, 8'h12, 8'h12, 8'h12, 8'hEC, 8'h00);
      7'd51: g = mk(3'd6, 8'h00, 8'h4C, 8'h92, 8'h92, 8'h92, 8'h64, 8'h00);
      7'd52: g = mk(3'd6, 8'h00, 8'h02, 8'h02, 8'hFE, 8'h02, 8'h02, 8'h00);
      7'd53: g = mk(3'd6, 8'h00, 8'h7E, 8'h80, 8'h80, 8'h80, 8'h7E, 8'h00);
      7'd54: g = mk(3'd6, 8'h00, 8'h1E, 8'h60, 8'h80, 8'h60, 8'h1E, 8'h00);
      7'd55: g = mk(3'd6, 8'h00, 8'hFE, 8'h80, 8'h70, 8'h80, 8'hFE, 8'h00);
      7'd56: g = mk(3'd6, 8'h00, 8'h82, 8'h6C, 8'h10, 8'h6C, 8'h82, 8'h00);
      7'd57: g = mk(3'd6, 8'h00, 8'h02, 8'h0C, 8'hF0, 8'h0C, 8'h02, 8'h00);
      7'd58: g = mk(3'd6, 8'h00, 8'h82, 8'hE2, 8'h92, 8'h8E, 8'h82, 8'h00);
      7'd59: g = mk(3'd4, 8'h00, 8'h00, 8'hFE, 8'h82, 8'h00, 8'h00, 8'h00);
      7'd60: g = mk(3'd6, 8'h00, 8'h02, 8'h0C, 8'h10, 8'h60, 8'h80, 8'h00);
      7'd61: g = mk(3'd4, 8'h00, 8'h82, 8'hFE, 8'h00, 8'h00, 8'h00, 8'h00);
      7'd62: g = mk(3'd6, 8'h00, 8'h08, 8'h04, 8'h02, 8'h04, 8'h08, 8'h00);
      7'd63: g = mk(3'd6, 8'h00, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h00);
      7'd64: g = mk(3'd3, 8'h00, 8'h06, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00);
      7'd65: g = mk(3'd4, 8'h00, 8'h10, 8'h7C, 8'h82, 8'h00, 8'h00, 8'h00);
      7'd66: g = mk(3'd2, 8'h00, 8'hFE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      7'd67: g = mk(3'd4, 8'h00, 8'h82, 8'h7C, 8'h10, 8'h00, 8'h00, 8'h00);
      7'd68: g = mk(3'd6, 8'h00, 8'h10, 8'h08, 8'h10, 8'h20, 8'h10, 8'h00);
      7'd69: g = mk(3'd6, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      7'd70: g = mk(3'd6, 8'h88, 8'h22, 8'h88, 8'h22, 8'h88, 8'h22, 8'h88);
      7'd71: g = mk(3'd6, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA);
      7'd72: g = mk(3'd6, 8'h77, 8'hDD, 8'h77, 8'hDD, 8'h77, 8'hDD, 8'h77);
      7'd73: g = mk(3'd6, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      7'd74: g = mk(3'd6, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00);
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

FILE: rtl/tgr_font_rom.sv
// ----------------------------------------------------------------------------
// tgr_font_rom
// Synchronous font ROM: one glyph word (length and seven column bytes) per
// entry, read data registered in the cycle after the address.
// ----------------------------------------------------------------------------
module tgr_font_rom
  import tgr_pkg::*;
(
  input  logic             clk,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output glyph_t           rd_data
);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= font_word(rd_addr);
    end
  end

endmodule

FILE: rtl/text_glyph_renderer_core.sv
// ----------------------------------------------------------------------------
// text_glyph_renderer_core
// Character-to-frame-buffer-write renderer with a text cursor.
// ----------------------------------------------------------------------------
// One character transfer in, zero to 28 frame-buffer write transfers out. A
// drawable character is accepted while idle, which reads the font ROM; S_FETCH
// loads the glyph and S_EMIT then makes one write per cycle while the output
// is not stalled, paced by the single output register: len writes at normal
// size and 4*len when doubled. Home and newline produce nothing; an
// unrenderable code gives one status transfer. The input stalls while a
// character is being drawn; the output register lets a new character be
// taken while the final write still waits downstream.
module text_glyph_renderer_core
  import tgr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              opcode,
  input  logic [7:0]        char_code,
  // output channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic              write_enable,
  output logic [ADDR_W-1:0] write_address,
  output logic [7:0]        write_data,
  output logic [1:0]        status,
  output logic              last,
  // configuration
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic              cfg_data
);

  state_t state, state_next;

  logic                invert_pixels;
  logic                double_size;
  logic [CURSOR_W-1:0] cursor;
  glyph_t              glyph;
  glyph_t              rom_data;
  logic [COL_W-1:0]    col_idx;
  logic [1:0]          sub_idx;

  logic             in_xfer;
  logic             out_free;
  logic             is_newline;
  logic             is_bad;
  logic [IDX_W-1:0] glyph_idx;
  logic             emit;
  logic             emit_err;
  logic             emit_last;
  logic             col_last;
  logic             sub_last;
  logic [7:0]       col_byte;
  logic [7:0]       emit_byte;
  logic [SUM_W-1:0] offset;
  logic [SUM_W-1:0] addr_sum;
  logic             in_frame;

  function automatic logic [7:0] spread_nibble(input logic [3:0] nib);
    logic [7:0] r;
    for (int b = 0; b < 4; b++) begin
      r[2*b]   = nib[b];
      r[2*b+1] = nib[b];
    end
    return r;
  endfunction

  assign out_free   = !out_valid || !out_stall;
  assign in_xfer    = in_valid && !in_stall;
  assign is_newline = (char_code == CHAR_NEWLINE);
  assign is_bad     = (char_code < CHAR_FIRST) || (char_code > CHAR_LAST);

  // fold lower case onto upper case; codes above the lower case block follow 96
  always_comb begin
    if (char_code >= CHAR_LOWER_A && char_code <= CHAR_LOWER_Z) begin
      glyph_idx = IDX_W'(char_code - 8'd64);
    end else if (char_code >= CHAR_EXTRA) begin
      glyph_idx = IDX_W'(char_code - 8'd58);
    end else begin
      glyph_idx = IDX_W'(char_code - CHAR_FIRST);
    end
  end

  tgr_font_rom u_rom (
    .clk     (clk),
    .rd_en   (in_xfer),
    .rd_addr (glyph_idx),
    .rd_data (rom_data)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_xfer && !opcode && !is_newline) begin
          state_next = is_bad ? S_ERR : S_FETCH;
        end
      end
      S_FETCH: state_next = S_EMIT;
      S_EMIT: begin
        if (out_free && emit_last) state_next = S_IDLE;
      end
      S_ERR: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall = 1'b1;
    emit     = 1'b0;
    emit_err = 1'b0;
    unique case (state)
      S_IDLE:  in_stall = 1'b0;
      S_FETCH: in_stall = 1'b1;
      S_EMIT:  emit     = out_free;
      S_ERR:   emit_err = out_free;
      default: in_stall = 1'b1;
    endcase
  end

  assign col_last  = (LEN_W'(col_idx) == glyph.len - LEN_W'(1));
  assign sub_last  = double_size ? (sub_idx == 2'd3) : 1'b1;
  assign emit_last = col_last && sub_last;

  assign col_byte  = glyph.cols[col_idx] ^ {8{invert_pixels}};

  always_comb begin
    if (!double_size) begin
      emit_byte = col_byte;
      offset    = SUM_W'(col_idx);
    end else begin
      emit_byte = sub_idx[1] ? spread_nibble(col_byte[7:4]) : spread_nibble(col_byte[3:0]);
      offset    = SUM_W'({col_idx, 1'b0}) + SUM_W'(sub_idx[0])
                + (sub_idx[1] ? SUM_W'(ROW_BYTES) : '0);
    end
  end

  assign addr_sum = SUM_W'(cursor) + offset;
  assign in_frame = (addr_sum < SUM_W'(FRAME_BYTES));

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      invert_pixels <= 1'b0;
      double_size   <= 1'b0;
      cursor        <= '0;
      out_valid     <= 1'b0;
      col_idx       <= '0;
      sub_idx       <= '0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        case (cfg_index)
          CFG_INVERT: invert_pixels <= cfg_data;
          CFG_DOUBLE: double_size   <= cfg_data;
          default:    ;
        endcase
      end

      if (in_xfer) begin
        if (opcode) begin
          cursor <= '0;
        end else if (is_newline) begin
          cursor <= cursor & ~CURSOR_W'(ROW_BYTES - 1);
        end
      end

      if (state == S_FETCH) begin
        col_idx <= '0;
        sub_idx <= '0;
      end

      if (emit) begin
        if (sub_last) begin
          sub_idx <= '0;
          col_idx <= col_idx + COL_W'(1);
        end else begin
          sub_idx <= sub_idx + 2'd1;
        end
        if (emit_last) begin
          cursor <= cursor + (double_size ? CURSOR_W'({glyph.len, 1'b0})
                                          : CURSOR_W'(glyph.len));
        end
      end

      if (emit || emit_err) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_FETCH) begin
      glyph <= rom_data;
    end
    if (emit_err) begin
      write_enable  <= 1'b0;
      write_address <= '0;
      write_data    <= '0;
      status        <= STAT_BADCHAR;
      last          <= 1'b1;
    end else if (emit) begin
      write_enable  <= in_frame;
      write_address <= in_frame ? addr_sum[ADDR_W-1:0] : '0;
      write_data    <= in_frame ? emit_byte : '0;
      status        <= in_frame ? STAT_OK : STAT_CLIPPED;
      last          <= emit_last;
    end
  end

endmodule
